// ===== hw/rtl/ncm_pkg.sv =====
// Shared types, constants and codes for the neighbour arrival-count node.
package ncm_pkg;

    // Default structural widths
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int PEER_COUNT_W = 8;
    localparam int OUT_COUNT_W  = 8;
    localparam int TOTAL_W      = 8;
    localparam int RADIUS_W     = 34;
    localparam int TIMER_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = RADIUS_W;
    localparam int M_DATA_W     = 16;

    // Configuration reset values
    localparam logic [TOTAL_W-1:0]  TOTAL_NODES_RST     = TOTAL_W'(8);
    localparam logic [RADIUS_W-1:0] RADIUS_SQUARED_RST  = RADIUS_W'(25600);
    localparam logic [TIMER_W-1:0]  WAIT_TICKS_RST      = TIMER_W'(200);
    localparam logic [TIMER_W-1:0]  HEARTBEAT_TICKS_RST = TIMER_W'(50);

    typedef enum logic [1:0] {
        OP_REACHED = 2'd0,
        OP_LEFT    = 2'd1,
        OP_TICK    = 2'd2,
        OP_PEER    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_NODES     = 2'd0,
        CFG_RADIUS_SQUARED  = 2'd1,
        CFG_WAIT_TICKS      = 2'd2,
        CFG_HEARTBEAT_TICKS = 2'd3
    } cfg_idx_t;

    // Event after the range check, handed to the node state logic
    typedef struct packed {
        op_t                     op;
        logic [PEER_COUNT_W-1:0] peer_count;
        logic                    in_range;
    } dist_item_t;

    // Configuration seen by the node state logic
    typedef struct packed {
        logic [TOTAL_W-1:0] total_nodes;
        logic [TIMER_W-1:0] wait_ticks;
        logic [TIMER_W-1:0] heartbeat_ticks;
    } node_cfg_t;

    // Result word, send_request in the lowest bit
    typedef struct packed {
        logic                   misuse;
        logic                   count_conflict;
        logic [1:0]             mode;
        logic                   all_arrived;
        logic [OUT_COUNT_W-1:0] arrived_count;
        logic                   send_request;
    } node_result_t;

endpackage

// ===== hw/rtl/ncm_dist.sv =====
// Three-stage pipeline: input register, squared axis distances, radius check.
module ncm_dist #(
    parameter int COORD_WIDTH = ncm_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ncm_pkg::op_t                          in_op,
    input  logic [2:0][COORD_WIDTH-1:0]           own_pos,
    input  logic [2:0][COORD_WIDTH-1:0]           peer_pos,
    input  logic [ncm_pkg::PEER_COUNT_W-1:0]      peer_count,
    input  logic [ncm_pkg::RADIUS_W-1:0]          radius_squared,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ncm_pkg::dist_item_t                   out_item
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > ncm_pkg::RADIUS_W) ? SUM_W : ncm_pkg::RADIUS_W;

    logic [2:0] valid_reg;
    logic [2:0] en;

    // stage 0: input register
    ncm_pkg::op_t                     op0_reg;
    logic [ncm_pkg::PEER_COUNT_W-1:0] pc0_reg;
    logic [2:0][COORD_WIDTH-1:0]      own0_reg;
    logic [2:0][COORD_WIDTH-1:0]      peer0_reg;

    // stage 1: squares
    ncm_pkg::op_t                     op1_reg;
    logic [ncm_pkg::PEER_COUNT_W-1:0] pc1_reg;
    logic [2:0][SQ_W-1:0]             sq1_reg;
    logic [2:0][SQ_W-1:0]             sq1_next;

    // stage 2: range flag
    ncm_pkg::dist_item_t item2_reg;
    ncm_pkg::dist_item_t item2_next;

    logic signed [DIFF_W-1:0] diff [3];
    logic        [DIFF_W-1:0] mag  [3];
    logic        [SUM_W-1:0]  dist_sum;

    // stall chain, bubbles collapse
    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = DIFF_W'($signed(peer0_reg[a])) - DIFF_W'($signed(own0_reg[a]));
            mag[a]  = diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
            sq1_next[a] = SQ_W'(mag[a]) * SQ_W'(mag[a]);
        end
    end

    always_comb
    begin
        dist_sum = SUM_W'(sq1_reg[0]) + SUM_W'(sq1_reg[1]) + SUM_W'(sq1_reg[2]);
        item2_next.op         = op1_reg;
        item2_next.peer_count = pc1_reg;
        // zero distance is the node's own message
        item2_next.in_range   = (dist_sum != '0)
                              && (CMP_W'(dist_sum) <= CMP_W'(radius_squared));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            if (en[1]) valid_reg[1] <= valid_reg[0];
            if (en[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op0_reg   <= in_op;
            pc0_reg   <= peer_count;
            own0_reg  <= own_pos;
            peer0_reg <= peer_pos;
        end
        if (en[1])
        begin
            op1_reg <= op0_reg;
            pc1_reg <= pc0_reg;
            sq1_reg <= sq1_next;
        end
        if (en[2])
        begin
            item2_reg <= item2_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_item  = item2_reg;

    // a stalled input means every stage holds an item
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (valid_reg == 3'b111))
        else $error("input stalled with an empty stage");

    // a held output keeps its item
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && !out_ready) |=> (valid_reg[2] && $stable(item2_reg)))
        else $error("range stage changed while stalled");

endmodule

// ===== hw/rtl/ncm_node.sv =====
// Node mode, count and timers, with the registered result.
module ncm_node #(
    parameter int COUNT_WIDTH = ncm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ncm_pkg::dist_item_t   in_item,
    input  ncm_pkg::node_cfg_t    cfg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ncm_pkg::node_result_t out_result
);

    localparam int EXT_W = (COUNT_WIDTH > ncm_pkg::OUT_COUNT_W) ? COUNT_WIDTH
                                                                 : ncm_pkg::OUT_COUNT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_AWAY    = 2'd0,
        MODE_ARRIVED = 2'd1,
        MODE_BCAST   = 2'd2,
        MODE_LISTEN  = 2'd3
    } mode_t;

    mode_t                          mode_reg,       mode_next;
    logic [COUNT_WIDTH-1:0]         count_reg,      count_next;
    logic [ncm_pkg::TIMER_W-1:0]    wait_ctr_reg,   wait_ctr_next;
    logic                           wait_armed_reg, wait_armed_next;
    logic [ncm_pkg::TIMER_W-1:0]    beat_ctr_reg,   beat_ctr_next;
    logic                           res_valid_reg,  res_valid_next;
    ncm_pkg::node_result_t          res_reg,        res_next;

    logic                           take;
    logic                           started;
    logic [ncm_pkg::TIMER_W-1:0]    wait_inc;
    logic [ncm_pkg::TIMER_W-1:0]    beat_inc;
    logic [COUNT_WIDTH-1:0]         pc;
    logic [COUNT_WIDTH:0]           pc_inc;
    logic [COUNT_WIDTH:0]           merge_sum;
    logic [EXT_W-1:0]               count_ext;

    assign in_ready = !res_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        wait_ctr_next   = wait_ctr_reg;
        wait_armed_next = wait_armed_reg;
        beat_ctr_next   = beat_ctr_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !out_ready;
        started         = 1'b0;
        wait_inc        = wait_ctr_reg + 1'b1;
        beat_inc        = beat_ctr_reg + 1'b1;
        pc              = COUNT_WIDTH'(in_item.peer_count);
        pc_inc          = {1'b0, pc} + 1'b1;
        merge_sum       = {1'b0, count_reg} + {1'b0, pc};
        count_ext       = '0;

        if (take)
        begin
            // event flags start clear; a held result keeps its own
            res_next.send_request   = 1'b0;
            res_next.count_conflict = 1'b0;
            res_next.misuse         = 1'b0;

            case (in_item.op)
                ncm_pkg::OP_REACHED:
                begin
                    if (mode_reg == MODE_AWAY)
                    begin
                        mode_next       = MODE_ARRIVED;
                        wait_ctr_next   = '0;
                        wait_armed_next = 1'b1;
                    end
                end
                ncm_pkg::OP_LEFT:
                begin
                    res_next.misuse = (mode_reg == MODE_ARRIVED) || (mode_reg == MODE_BCAST);
                    mode_next       = MODE_AWAY;
                    wait_armed_next = 1'b0;
                end
                ncm_pkg::OP_TICK:
                begin
                    if (wait_armed_reg)
                    begin
                        wait_ctr_next = wait_inc;
                        // counter wrap counts as expiry too
                        if (wait_inc >= cfg.wait_ticks || wait_inc == '0)
                        begin
                            wait_armed_next = 1'b0;
                            if (mode_reg == MODE_ARRIVED)
                            begin
                                count_next            = COUNT_WIDTH'(1);
                                mode_next             = MODE_BCAST;
                                beat_ctr_next         = '0;
                                res_next.send_request = 1'b1;
                                started               = 1'b1;
                            end
                        end
                    end
                    if (!started && mode_reg == MODE_BCAST)
                    begin
                        beat_ctr_next = beat_inc;
                        if (beat_inc >= cfg.heartbeat_ticks || beat_inc == '0)
                        begin
                            beat_ctr_next         = '0;
                            res_next.send_request = 1'b1;
                        end
                    end
                end
                ncm_pkg::OP_PEER:
                begin
                    if (in_item.in_range)
                    begin
                        case (mode_reg)
                            MODE_ARRIVED:
                            begin
                                count_next = pc_inc[COUNT_WIDTH] ? COUNT_MAX
                                                                 : pc_inc[COUNT_WIDTH-1:0];
                                mode_next             = MODE_BCAST;
                                beat_ctr_next         = '0;
                                res_next.send_request = 1'b1;
                            end
                            MODE_BCAST:
                            begin
                                if (pc < count_reg)
                                begin
                                    count_next = merge_sum[COUNT_WIDTH] ? COUNT_MAX
                                                 : merge_sum[COUNT_WIDTH-1:0];
                                end
                                else if (pc > count_reg)
                                begin
                                    count_next = pc;
                                    mode_next  = MODE_LISTEN;
                                end
                                else
                                begin
                                    res_next.count_conflict = 1'b1;
                                end
                            end
                            MODE_LISTEN:
                            begin
                                if (pc > count_reg)
                                begin
                                    count_next = pc;
                                end
                            end
                            default:
                            begin
                                // away: peer messages are ignored
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase

            count_ext              = EXT_W'(count_next);
            res_next.arrived_count = (count_ext > EXT_W'({ncm_pkg::OUT_COUNT_W{1'b1}}))
                                   ? {ncm_pkg::OUT_COUNT_W{1'b1}}
                                   : count_ext[ncm_pkg::OUT_COUNT_W-1:0];
            res_next.all_arrived   = count_ext >= EXT_W'(cfg.total_nodes);
            res_next.mode          = mode_next;
            res_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_AWAY;
            count_reg      <= '0;
            wait_ctr_reg   <= '0;
            wait_armed_reg <= 1'b0;
            beat_ctr_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            wait_ctr_reg   <= wait_ctr_next;
            wait_armed_reg <= wait_armed_next;
            beat_ctr_reg   <= beat_ctr_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

    a_away_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_AWAY) |-> !wait_armed_reg)
        else $error("wait armed while away");

    a_send_in_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.send_request) |-> (res_reg.mode == MODE_BCAST))
        else $error("send request outside broadcasting");

    a_conflict_in_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.count_conflict) |-> (res_reg.mode == MODE_BCAST))
        else $error("count conflict outside broadcasting");

    a_misuse_away: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.misuse) |-> (res_reg.mode == MODE_AWAY))
        else $error("misuse flagged without leaving");

endmodule

// ===== hw/rtl/neighbour_count_merge_protocol.sv =====
// Top level of the neighbour arrival-count node: ports, config registers, pipeline.
//
// A result shows on m_* once its input transfer has passed the input register,
//   squared-distance multipliers, radius compare and node state register.
// Throughput: one item per cycle; a stalled m_tready backs up through the
//   four registered stages, each of which keeps accepting while a slot is free.
// Reset (rst_n, async active low): pipeline emptied, node away with count zero
//   and timers cleared, configuration back to its defaults (8, 25600, 200, 50).
module neighbour_count_merge_protocol #(
    parameter int COORD_WIDTH = ncm_pkg::COORD_WIDTH_DEF,
    parameter int COUNT_WIDTH = ncm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, low to high: own_x, own_y, own_z, peer_x, peer_y, peer_z, peer_count, zero pad
    input  logic [((6 * COORD_WIDTH + ncm_pkg::PEER_COUNT_W + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: operation
    input  logic [1:0]                        s_tuser,

    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, low to high: send_request, arrived_count, all_arrived, mode,
    // count_conflict, misuse, zero pad
    output logic [ncm_pkg::M_DATA_W-1:0]      m_tdata,

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ncm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ncm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int RES_W      = $bits(ncm_pkg::node_result_t);

    // configuration registers
    logic [ncm_pkg::TOTAL_W-1:0]  total_nodes_reg;
    logic [ncm_pkg::RADIUS_W-1:0] radius_squared_reg;
    logic [ncm_pkg::TIMER_W-1:0]  wait_ticks_reg;
    logic [ncm_pkg::TIMER_W-1:0]  heartbeat_ticks_reg;

    logic [2:0][COORD_WIDTH-1:0]  own_pos;
    logic [2:0][COORD_WIDTH-1:0]  peer_pos;
    logic [ncm_pkg::PEER_COUNT_W-1:0] peer_count;

    logic                         dist_valid;
    logic                         dist_ready;
    ncm_pkg::dist_item_t          dist_item;
    ncm_pkg::node_cfg_t           node_cfg;
    ncm_pkg::node_result_t        result;

    // Config is written only while idle, so a write is always taken. It is not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_nodes_reg     <= ncm_pkg::TOTAL_NODES_RST;
            radius_squared_reg  <= ncm_pkg::RADIUS_SQUARED_RST;
            wait_ticks_reg      <= ncm_pkg::WAIT_TICKS_RST;
            heartbeat_ticks_reg <= ncm_pkg::HEARTBEAT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ncm_pkg::cfg_idx_t'(cfg_index))
                ncm_pkg::CFG_TOTAL_NODES:
                    total_nodes_reg <= cfg_data[ncm_pkg::TOTAL_W-1:0];
                ncm_pkg::CFG_RADIUS_SQUARED:
                    radius_squared_reg <= cfg_data[ncm_pkg::RADIUS_W-1:0];
                ncm_pkg::CFG_WAIT_TICKS:
                    wait_ticks_reg <= cfg_data[ncm_pkg::TIMER_W-1:0];
                ncm_pkg::CFG_HEARTBEAT_TICKS:
                    heartbeat_ticks_reg <= cfg_data[ncm_pkg::TIMER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // unpack the input transfer; axis 0 is x
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            own_pos[a]  = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
            peer_pos[a] = s_tdata[(a+3)*COORD_WIDTH +: COORD_WIDTH];
        end
        peer_count = s_tdata[6*COORD_WIDTH +: ncm_pkg::PEER_COUNT_W];
    end

    assign node_cfg.total_nodes     = total_nodes_reg;
    assign node_cfg.wait_ticks      = wait_ticks_reg;
    assign node_cfg.heartbeat_ticks = heartbeat_ticks_reg;

    ncm_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (ncm_pkg::op_t'(s_tuser)),
        .own_pos        (own_pos),
        .peer_pos       (peer_pos),
        .peer_count     (peer_count),
        .radius_squared (radius_squared_reg),
        .out_valid      (dist_valid),
        .out_ready      (dist_ready),
        .out_item       (dist_item)
    );

    ncm_node #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_node (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dist_valid),
        .in_ready   (dist_ready),
        .in_item    (dist_item),
        .cfg        (node_cfg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = ncm_pkg::M_DATA_W'(RES_W'(result));

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the neighbour arrival-count node.
module testbench;

    // tdata is six 16-bit coordinates plus the 8-bit peer count: 104 bits, already whole bytes
    localparam int COORD_W  = 16;
    localparam int S_DATA_W = 6 * COORD_W + ncm_pkg::PEER_COUNT_W;
    localparam int RESULT_W = $bits(ncm_pkg::node_result_t);

    // Node modes as they show on the result word
    typedef enum logic [1:0] {
        MODE_AWAY    = 2'd0,
        MODE_ARRIVED = 2'd1,
        MODE_BCAST   = 2'd2,
        MODE_LISTEN  = 2'd3
    } node_mode_t;

    // One event as the sender sees it
    typedef struct packed {
        ncm_pkg::op_t                     op;
        logic signed [COORD_W-1:0]        own_x;
        logic signed [COORD_W-1:0]        own_y;
        logic signed [COORD_W-1:0]        own_z;
        logic signed [COORD_W-1:0]        peer_x;
        logic signed [COORD_W-1:0]        peer_y;
        logic signed [COORD_W-1:0]        peer_z;
        logic [ncm_pkg::PEER_COUNT_W-1:0] peer_count;
    } node_event_t;

    localparam int EVENT_W = $bits(node_event_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tdata, low to high: own_x, own_y, own_z, peer_x, peer_y, peer_z, peer_count
    logic [S_DATA_W-1:0]   s_tdata = '0;
    // tuser: operation
    logic [1:0]            s_tuser = '0;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata, low to high: send_request, arrived_count, all_arrived, mode,
    // count_conflict, misuse, zero pad
    logic [ncm_pkg::M_DATA_W-1:0]   m_tdata;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ncm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ncm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted node state and configuration, updated on each accepted transfer
    node_mode_t                     mode_q;
    logic [7:0]                     count_q;
    logic [ncm_pkg::TIMER_W-1:0]    wait_cnt_q;
    logic                           wait_armed_q;
    logic [ncm_pkg::TIMER_W-1:0]    beat_cnt_q;
    logic [ncm_pkg::TOTAL_W-1:0]    cfg_total;
    logic [ncm_pkg::RADIUS_W-1:0]   cfg_radius;
    logic [ncm_pkg::TIMER_W-1:0]    cfg_wait;
    logic [ncm_pkg::TIMER_W-1:0]    cfg_beat;

    // Results still owed by the node, oldest first
    ncm_pkg::node_result_t pending_results[$];

    // Gap control; both switched per phase
    bit                    idle_on = 1'b1;
    bit                    stall_on = 1'b1;
    int                    stall_left = 0;

    int                    errors = 0;
    int                    events_sent = 0;
    int                    results_checked = 0;
    int                    sends_seen = 0;
    int                    conflicts_seen = 0;

    neighbour_count_merge_protocol dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver backpressure
    always @(posedge clk)
    begin : drive_ready
        int gap;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            gap = (stall_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (gap > 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= gap - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] axis_sq(input logic signed [COORD_W-1:0] a,
                                            input logic signed [COORD_W-1:0] b);
        longint diff;
        diff = longint'(a) - longint'(b);
        return diff * diff;
    endfunction

    // Next node state and the result word for one event
    function automatic ncm_pkg::node_result_t predict_event(input node_event_t ev);
        ncm_pkg::node_result_t res;
        logic [63:0]  dist_sq;
        logic [8:0]   merged;
        logic         started;
        res     = '0;
        started = 1'b0;
        dist_sq = axis_sq(ev.peer_x, ev.own_x) + axis_sq(ev.peer_y, ev.own_y)
                + axis_sq(ev.peer_z, ev.own_z);
        case (ev.op)
            ncm_pkg::OP_REACHED:
            begin
                // ignored unless away
                if (mode_q == MODE_AWAY)
                begin
                    mode_q       = MODE_ARRIVED;
                    wait_cnt_q   = '0;
                    wait_armed_q = 1'b1;
                end
            end
            ncm_pkg::OP_LEFT:
            begin
                res.misuse   = (mode_q == MODE_ARRIVED || mode_q == MODE_BCAST);
                mode_q       = MODE_AWAY;
                wait_armed_q = 1'b0;
            end
            ncm_pkg::OP_TICK:
            begin
                if (wait_armed_q)
                begin
                    wait_cnt_q = wait_cnt_q + 1'b1;
                    if (wait_cnt_q >= cfg_wait || wait_cnt_q == '0)
                    begin
                        // expiry outside arrived mode only disarms
                        wait_armed_q = 1'b0;
                        if (mode_q == MODE_ARRIVED)
                        begin
                            count_q          = 8'd1;
                            mode_q           = MODE_BCAST;
                            beat_cnt_q       = '0;
                            res.send_request = 1'b1;
                            started          = 1'b1;
                        end
                    end
                end
                // no heartbeat on the tick that starts broadcasting
                if (!started && mode_q == MODE_BCAST)
                begin
                    beat_cnt_q = beat_cnt_q + 1'b1;
                    if (beat_cnt_q >= cfg_beat || beat_cnt_q == '0)
                    begin
                        beat_cnt_q       = '0;
                        res.send_request = 1'b1;
                    end
                end
            end
            ncm_pkg::OP_PEER:
            begin
                // zero distance is our own echo; beyond radius is not heard
                if (dist_sq != 64'd0 && dist_sq <= 64'(cfg_radius))
                begin
                    case (mode_q)
                        MODE_ARRIVED:
                        begin
                            count_q = (ev.peer_count == 8'hFF) ? 8'hFF
                                                               : ev.peer_count + 8'd1;
                            mode_q           = MODE_BCAST;
                            beat_cnt_q       = '0;
                            res.send_request = 1'b1;
                        end
                        MODE_BCAST:
                        begin
                            if (ev.peer_count < count_q)
                            begin
                                merged  = {1'b0, count_q} + {1'b0, ev.peer_count};
                                count_q = merged[8] ? 8'hFF : merged[7:0];
                            end
                            else if (ev.peer_count > count_q)
                            begin
                                count_q = ev.peer_count;
                                mode_q  = MODE_LISTEN;
                            end
                            else
                                res.count_conflict = 1'b1;
                        end
                        MODE_LISTEN:
                        begin
                            if (ev.peer_count > count_q)
                                count_q = ev.peer_count;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        res.arrived_count = count_q;
        res.all_arrived   = (count_q >= cfg_total);
        res.mode          = mode_q;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("result field %s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker: every result transfer is matched against the oldest prediction
    always @(posedge clk)
    begin : check_results
        ncm_pkg::node_result_t got;
        ncm_pkg::node_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = ncm_pkg::node_result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                sends_seen     += got.send_request;
                conflicts_seen += got.count_conflict;
                check_field("send_request", want.send_request, got.send_request);
                check_field("arrived_count", want.arrived_count, got.arrived_count);
                check_field("all_arrived", want.all_arrived, got.all_arrived);
                check_field("mode", want.mode, got.mode);
                check_field("count_conflict", want.count_conflict, got.count_conflict);
                check_field("misuse", want.misuse, got.misuse);
            end
        end
    end

    // Sends one event; tvalid stays high afterwards so back-to-back transfers
    // follow without a gap. Called at a rising edge.
    task automatic send_event(input node_event_t ev);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.op;
        s_tdata  <= {ev.peer_count, ev.peer_z, ev.peer_y, ev.peer_x,
                     ev.own_z, ev.own_y, ev.own_x};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_event(ev));
        events_sent++;
    endtask

    // Event with every field but op random; only op matters unless it is a peer message
    function automatic node_event_t random_event(input ncm_pkg::op_t op);
        node_event_t ev;
        ev            = node_event_t'(EVENT_W'({$urandom, $urandom, $urandom, $urandom}));
        ev.op         = op;
        return ev;
    endfunction

    function automatic node_event_t peer_event(input int ox, input int oy, input int oz,
                                               input int dx, input int dy, input int dz,
                                               input int pc);
        node_event_t ev;
        ev.op         = ncm_pkg::OP_PEER;
        ev.own_x      = COORD_W'(ox);
        ev.own_y      = COORD_W'(oy);
        ev.own_z      = COORD_W'(oz);
        ev.peer_x     = COORD_W'(ox + dx);
        ev.peer_y     = COORD_W'(oy + dy);
        ev.peer_z     = COORD_W'(oz + dz);
        ev.peer_count = pc[ncm_pkg::PEER_COUNT_W-1:0];
        return ev;
    endfunction

    // Stop sending and let the node drain everything it owes
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One register transfer; cfg_valid is left high for the next one
    task automatic write_register(input ncm_pkg::cfg_idx_t idx,
                                  input logic [ncm_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ncm_pkg::CFG_TOTAL_NODES:     cfg_total  = value[ncm_pkg::TOTAL_W-1:0];
            ncm_pkg::CFG_RADIUS_SQUARED:  cfg_radius = value[ncm_pkg::RADIUS_W-1:0];
            ncm_pkg::CFG_WAIT_TICKS:      cfg_wait   = value[ncm_pkg::TIMER_W-1:0];
            ncm_pkg::CFG_HEARTBEAT_TICKS: cfg_beat   = value[ncm_pkg::TIMER_W-1:0];
            default: ;
        endcase
    endtask

    // Node must be idle; writes all four registers
    task automatic set_config(input logic [ncm_pkg::TOTAL_W-1:0] total,
                              input logic [ncm_pkg::RADIUS_W-1:0] radius,
                              input logic [ncm_pkg::TIMER_W-1:0] wait_t,
                              input logic [ncm_pkg::TIMER_W-1:0] beat_t);
        write_register(ncm_pkg::CFG_TOTAL_NODES, ncm_pkg::CFG_DATA_W'(total));
        write_register(ncm_pkg::CFG_RADIUS_SQUARED, ncm_pkg::CFG_DATA_W'(radius));
        write_register(ncm_pkg::CFG_WAIT_TICKS, ncm_pkg::CFG_DATA_W'(wait_t));
        write_register(ncm_pkg::CFG_HEARTBEAT_TICKS, ncm_pkg::CFG_DATA_W'(beat_t));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Event rules under the reset configuration (8 nodes, radius 160, wait 200, beat 50)
    task automatic test_event_rules();
        node_event_t ev;
        send_event(peer_event(100, -100, 5, 10, 0, 0, 3));     // heard while away: ignored
        send_event(random_event(ncm_pkg::OP_LEFT));            // left while away: no misuse
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(random_event(ncm_pkg::OP_REACHED));         // already arrived: ignored
        send_event(random_event(ncm_pkg::OP_TICK));
        send_event(peer_event(100, -100, 5, 0, 0, 0, 4));      // own echo
        send_event(peer_event(100, -100, 5, 161, 0, 0, 4));    // just outside radius
        send_event(peer_event(100, -100, 5, 0, 0, -160, 4));   // on the radius: start at 5
        send_event(random_event(ncm_pkg::OP_TICK));            // heartbeat count 1
        send_event(peer_event(100, -100, 5, 3, 4, 5, 5));      // equal count: conflict
        send_event(peer_event(100, -100, 5, -7, 2, 1, 2));     // smaller: merged to 7
        send_event(peer_event(100, -100, 5, 1, 1, 1, 1));      // 8: all arrived
        send_event(peer_event(100, -100, 5, 0, 9, 0, 200));    // larger: listen
        send_event(peer_event(100, -100, 5, 0, 9, 0, 100));    // listening keeps the max
        send_event(peer_event(100, -100, 5, 0, 9, 0, 255));
        send_event(random_event(ncm_pkg::OP_LEFT));            // from listening: no misuse
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(peer_event(100, -100, 5, 2, 0, 0, 255));    // count + 1 saturates
        send_event(peer_event(100, -100, 5, 2, 0, 0, 0));
        send_event(random_event(ncm_pkg::OP_LEFT));            // misuse from broadcasting
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(peer_event(-2000, 3000, 0, 0, -50, 60, 199));
        send_event(peer_event(-2000, 3000, 0, 0, -50, 60, 100)); // merge saturates at 255
        send_event(random_event(ncm_pkg::OP_LEFT));
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(random_event(ncm_pkg::OP_LEFT));            // misuse from arrived
        // coordinate extremes; far apart so not heard
        ev = peer_event(-32768, -32768, -32768, 65535, 65535, 65535, 9);
        send_event(ev);
        drain_results();
    endtask

    // Extreme and zero register settings
    task automatic test_config_extremes();
        set_config(8'd1, {ncm_pkg::RADIUS_W{1'b1}}, 16'd1, 16'd1);
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(random_event(ncm_pkg::OP_TICK));            // wait done: count 1, send
        repeat (3) send_event(random_event(ncm_pkg::OP_TICK)); // heartbeat every tick
        // opposite corners are still inside the widest radius
        send_event(peer_event(-32768, -32768, -32768, 65535, 65535, 65535, 0));
        send_event(peer_event(32767, 32767, 32767, -65535, -65535, -65535, 1));
        send_event(random_event(ncm_pkg::OP_LEFT));
        drain_results();

        set_config(8'hFF, '0, 16'hFFFF, 16'hFFFF);
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(peer_event(0, 0, 0, 1, 0, 0, 5));           // radius zero hears nobody
        repeat (3) send_event(random_event(ncm_pkg::OP_TICK));
        send_event(random_event(ncm_pkg::OP_LEFT));
        drain_results();

        // zero registers: all arrived always, every tick expires
        set_config('0, ncm_pkg::RADIUS_W'(25600), '0, '0);
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(random_event(ncm_pkg::OP_TICK));
        send_event(random_event(ncm_pkg::OP_TICK));
        send_event(random_event(ncm_pkg::OP_LEFT));
        drain_results();
    endtask

    // Wait runs out after a peer already started broadcasting
    task automatic test_wait_expiry_in_broadcast();
        set_config(8'd8, ncm_pkg::RADIUS_W'(25600), 16'd2, 16'd3);
        send_event(random_event(ncm_pkg::OP_REACHED));
        send_event(peer_event(500, 500, 500, 3, 3, 3, 2));
        repeat (4) send_event(random_event(ncm_pkg::OP_TICK));
        send_event(random_event(ncm_pkg::OP_LEFT));
        drain_results();
    endtask

    // Per-axis offset that keeps a peer inside the current radius; at least 1, so not for a squared radius under 3
    function automatic int near_bound();
        real r;
        r = $sqrt(real'(cfg_radius) / 3.0);
        if (r > 700.0)
            return 700;
        if (r < 1.0)
            return 1;
        return $rtoi(r);
    endfunction

    // Peer count steered around our own count to hit merge, adopt and conflict
    function automatic int pick_peer_count();
        case ($urandom_range(0, 6))
            0: return count_q;
            1: return (count_q == 0) ? 0 : count_q - 1;
            2: return (count_q == 8'hFF) ? 255 : count_q + 1;
            3: return $urandom_range(0, 15);
            4: return $urandom_range(0, 255);
            5: return 0;
            default: return 255;
        endcase
    endfunction

    function automatic int rand_offset(input int b);
        int v;
        v = $urandom_range(0, 2 * b);
        return v - b;
    endfunction

    // One random phase: mostly visits (reach, ticks and peers, leave), some noise
    task automatic random_phase(input int n_items, input bit gaps);
        int          sent;
        int          visit_len;
        int          b;
        int          far;
        int          ox, oy, oz;
        int          r;
        logic [ncm_pkg::RADIUS_W-1:0] radius;
        idle_on  = gaps;
        stall_on = gaps;
        case ($urandom_range(0, 3))
            0: radius = ncm_pkg::RADIUS_W'(25600);
            1: radius = ncm_pkg::RADIUS_W'($urandom_range(100, 400000));
            2: radius = {ncm_pkg::RADIUS_W{1'b1}};
            default: radius = ncm_pkg::RADIUS_W'($urandom_range(0, 50));
        endcase
        set_config(($urandom_range(0, 7) == 0) ? 8'hFF
                                               : ncm_pkg::TOTAL_W'($urandom_range(1, 12)),
                   radius, ncm_pkg::TIMER_W'($urandom_range(1, 8)),
                   ncm_pkg::TIMER_W'($urandom_range(1, 6)));
        b    = near_bound();
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_event(random_event(ncm_pkg::op_t'($urandom_range(0, 3))));
                sent++;
            end
            else
            begin
                ox = $urandom_range(0, 62000) - 31000;
                oy = $urandom_range(0, 62000) - 31000;
                oz = $urandom_range(0, 62000) - 31000;
                send_event(random_event(ncm_pkg::OP_REACHED));
                visit_len = $urandom_range(3, 25);
                repeat (visit_len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        send_event(random_event(ncm_pkg::OP_TICK));
                    else if (r < 80)
                        send_event(peer_event(ox, oy, oz, rand_offset(b), rand_offset(b),
                                              rand_offset(b), pick_peer_count()));
                    else if (r < 85)
                        send_event(peer_event(ox, oy, oz, 0, 0, 0, pick_peer_count()));
                    else if (r < 92)
                    begin
                        far = b + $urandom_range(1, 800);
                        send_event(peer_event(ox, oy, oz, far, rand_offset(b), -far,
                                              pick_peer_count()));
                    end
                    else if (r < 97)
                        send_event(random_event(ncm_pkg::OP_REACHED));
                    else
                        send_event(random_event(ncm_pkg::OP_LEFT));
                end
                send_event(random_event(ncm_pkg::OP_LEFT));
                sent += visit_len + 2;
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        random_phase(200, 1'b1);
        random_phase(200, 1'b0);    // back to back, no stalls
        random_phase(200, 1'b1);
        random_phase(200, 1'b1);
    endtask

    initial
    begin
        // predicted reset state
        mode_q       = MODE_AWAY;
        count_q      = '0;
        wait_cnt_q   = '0;
        wait_armed_q = 1'b0;
        beat_cnt_q   = '0;
        cfg_total    = ncm_pkg::TOTAL_NODES_RST;
        cfg_radius   = ncm_pkg::RADIUS_SQUARED_RST;
        cfg_wait     = ncm_pkg::WAIT_TICKS_RST;
        cfg_beat     = ncm_pkg::HEARTBEAT_TICKS_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_event_rules();
        test_config_extremes();
        test_wait_expiry_in_broadcast();
        test_random_traffic();

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("covered %0d events, %0d results checked", events_sent, results_checked);
        $display("sends %0d, count conflicts %0d, mismatches %0d",
                 sends_seen, conflicts_seen, errors);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Hang guard
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ncm_pkg.sv
hw/rtl/ncm_dist.sv
hw/rtl/ncm_node.sv
hw/rtl/neighbour_count_merge_protocol.sv
sim/testbench.sv
